// File: hdl/char_lcd_nibble_expander_sequencer_unit_assert.svh
// Assertion macros for the character LCD nibble expander sequencer.
`ifndef CHAR_LCD_NIBBLE_EXPANDER_SEQUENCER_UNIT_ASSERT_SVH
`define CHAR_LCD_NIBBLE_EXPANDER_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CLNES_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clnes assertion failed");

// Next-cycle implication, checked out of reset.
`define CLNES_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clnes assertion failed");

`endif

// File: hdl/clnes_pkg.sv
// Package: word types, codes, constants and the init table.
package clnes_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] DEV_ADDR_RESET = 8'h40;
  localparam logic [7:0] CURSOR_ROW0    = 8'h80;
  localparam logic [7:0] CURSOR_ROW1    = 8'hC0;
  localparam logic [7:0] HI_MASK        = 8'hF0;
  localparam logic [7:0] LO_MASK        = 8'h0F;
  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;

  localparam int unsigned BIT_RS = 0;
  localparam int unsigned BIT_RW = 1;
  localparam int unsigned BIT_E  = 2;

  localparam int unsigned INIT_IDX_W = 3;
  localparam logic [INIT_IDX_W-1:0] INIT_LAST = 3'd5;

  typedef enum logic [1:0] {
    ACT_CMD    = 2'd0,
    ACT_DATA   = 2'd1,
    ACT_CURSOR = 2'd2,
    ACT_INIT   = 2'd3
  } action_t;

  // One expander write per step of a byte send.
  typedef enum logic [2:0] {
    STEP_SETUP = 3'd0,
    STEP_HI    = 3'd1,
    STEP_HI_EH = 3'd2,
    STEP_HI_EL = 3'd3,
    STEP_LO    = 3'd4,
    STEP_LO_EH = 3'd5,
    STEP_LO_EL = 3'd6
  } step_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] value;
    logic [5:0] column;
    logic       row;
  } in_word_t;

  typedef struct packed {
    logic [7:0] bus_address;
    logic [7:0] expander_byte;
    logic       last;
  } out_word_t;

  // Queue entry: a full byte send, or a bare E pulse starting at STEP_LO_EH.
  typedef struct packed {
    logic       is_data;
    step_t      first_step;
    logic [7:0] byte_val;
    logic       last;
  } cmd_entry_t;

  function automatic cmd_entry_t send_entry(logic [7:0] b, logic is_data);
    cmd_entry_t e;
    e.is_data    = is_data;
    e.first_step = STEP_SETUP;
    e.byte_val   = b;
    e.last       = 1'b0;
    return e;
  endfunction

  function automatic cmd_entry_t init_entry(logic [INIT_IDX_W-1:0] idx);
    cmd_entry_t e;
    case (idx)
      3'd0, 3'd1, 3'd3: e = send_entry(CMD_FUNC_SET, 1'b0);
      3'd2: begin
        e            = send_entry(8'h00, 1'b0);
        e.first_step = STEP_LO_EH;
      end
      3'd4:    e = send_entry(CMD_DISP_ON, 1'b0);
      default: e = send_entry(CMD_CLEAR, 1'b0);
    endcase
    e.last = (idx == INIT_LAST);
    return e;
  endfunction

endpackage

// File: hdl/clnes_front.sv
// Front end: accepts input words and turns them into byte-send queue entries.
module clnes_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  clnes_pkg::in_word_t   in_data,
  input  logic                  q_full,
  output logic                  push,
  output clnes_pkg::cmd_entry_t push_entry,
  output logic                  busy
);
  import clnes_pkg::*;

  logic                  busy_r, busy_nxt;
  logic [INIT_IDX_W-1:0] idx_r, idx_nxt;
  logic                  accept;
  logic [7:0]            cursor_byte;

  assign in_stall = busy_r | q_full;
  assign accept   = in_valid & ~in_stall;
  assign push     = busy_r ? ~q_full : accept;
  assign busy     = busy_r;

  assign cursor_byte = (in_data.row ? CURSOR_ROW1 : CURSOR_ROW0) + {2'b00, in_data.column};

  always_comb begin
    push_entry = init_entry(idx_r);
    if (!busy_r) begin
      unique case (in_data.action)
        ACT_CMD:    push_entry = send_entry(in_data.value, 1'b0);
        ACT_DATA:   push_entry = send_entry(in_data.value, 1'b1);
        ACT_CURSOR: push_entry = send_entry(cursor_byte, 1'b0);
        ACT_INIT:   push_entry = init_entry('0);
        default:    push_entry = send_entry(in_data.value, 1'b0);
      endcase
      if (in_data.action != ACT_INIT) begin
        push_entry.last = 1'b1;
      end
    end
  end

  // Init spreads over six entries, one per cycle the queue has room.
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (busy_r) begin
      if (!q_full) begin
        if (idx_r == INIT_LAST) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end else if (accept && in_data.action == ACT_INIT) begin
      busy_nxt = 1'b1;
      idx_nxt  = INIT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

// File: hdl/clnes_queue.sv
// Short register FIFO of byte-send entries between front and back.
module clnes_queue #(
  parameter int unsigned DEPTH = clnes_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  clnes_pkg::cmd_entry_t push_entry,
  input  logic                  pop,
  output logic                  full,
  output logic                  head_valid,
  output clnes_pkg::cmd_entry_t head
);
  import clnes_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_entry_t      mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: hdl/clnes_back.sv
// Back end: steps the shadow byte through each entry, one expander write per cycle unless stalled.
module clnes_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  clnes_pkg::cmd_entry_t head,
  output logic                  pop,
  input  logic [7:0]            bus_address,
  output logic                  out_valid,
  input  logic                  out_stall,
  output clnes_pkg::out_word_t  out_data
);
  import clnes_pkg::*;

  logic [7:0] shadow_r, shadow_nxt;
  step_t      step_r, step_nxt;
  logic       started_r, started_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_data_r, out_data_nxt;
  step_t      step_eff;
  logic       load;
  logic [7:0] sh_new;

  function automatic logic [7:0] shadow_step(logic [7:0] sh, step_t st, cmd_entry_t e);
    logic [7:0] r;
    r = sh;
    unique case (st)
      STEP_SETUP: begin
        r[BIT_RS] = e.is_data;
        r[BIT_RW] = 1'b0;
      end
      STEP_HI:                r = (sh & LO_MASK) | (e.byte_val & HI_MASK);
      STEP_HI_EH, STEP_LO_EH: r[BIT_E] = 1'b1;
      STEP_HI_EL, STEP_LO_EL: r[BIT_E] = 1'b0;
      STEP_LO:                r = (sh & LO_MASK) | {e.byte_val[3:0], 4'h0};
      default:                r = sh;
    endcase
    return r;
  endfunction

  assign step_eff  = started_r ? step_r : head.first_step;
  assign load      = head_valid & (~out_valid_r | ~out_stall);
  assign sh_new    = shadow_step(shadow_r, step_eff, head);
  assign pop       = load & (step_eff == STEP_LO_EL);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    shadow_nxt    = shadow_r;
    step_nxt      = step_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    if (load) begin
      shadow_nxt                 = sh_new;
      out_valid_nxt              = 1'b1;
      out_data_nxt.bus_address   = bus_address;
      out_data_nxt.expander_byte = sh_new;
      out_data_nxt.last          = head.last & (step_eff == STEP_LO_EL);
      if (step_eff == STEP_LO_EL) begin
        started_nxt = 1'b0;
      end else begin
        started_nxt = 1'b1;
        step_nxt    = step_t'(step_eff + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shadow_r    <= '0;
      step_r      <= STEP_SETUP;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      shadow_r    <= shadow_nxt;
      step_r      <= step_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/char_lcd_nibble_expander_sequencer_unit.sv
// Top level: character LCD operations to I2C expander byte writes, 4-bit mode.
//
// Each input word becomes a run of expander writes, one output word per cycle
// unless out_stall holds it: command, data and cursor words give 7 writes,
// init gives 37. Throughput is set by the back-end sequencer, which emits one
// write per clock while not stalled. The front end turns each word into one
// queue entry (six for init; in_stall is high while the last five are queued)
// and parks entries in a short queue, so the next word is taken while the
// current one is still being written out. cfg_wr_data sets the I2C address
// byte (reset 0x40) carried with every write; write it only while idle.
`include "char_lcd_nibble_expander_sequencer_unit_assert.svh"

module char_lcd_nibble_expander_sequencer_unit #(
  parameter int unsigned QUEUE_DEPTH = clnes_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  clnes_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output clnes_pkg::out_word_t out_data,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data
);
  import clnes_pkg::*;

  logic [7:0] dev_addr_r, dev_addr_nxt;
  logic       q_full, q_push, q_pop, q_head_valid;
  logic       front_busy;
  cmd_entry_t q_push_entry, q_head;

  assign dev_addr_nxt = cfg_wr_en ? cfg_wr_data : dev_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RESET;
    end else begin
      dev_addr_r <= dev_addr_nxt;
    end
  end

  clnes_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_push_entry),
    .busy       (front_busy)
  );

  clnes_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  clnes_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (q_head_valid),
    .head        (q_head),
    .pop         (q_pop),
    .bus_address (dev_addr_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // A word's final write always leaves E low.
  `CLNES_ASSERT_IMP(a_last_e_low, out_valid && out_data.last, !out_data.expander_byte[BIT_E])
  // RW is never driven high on the expander.
  `CLNES_ASSERT_IMP(a_rw_low, out_valid, !out_data.expander_byte[BIT_RW])
  // No new word is taken while init entries are still being queued.
  `CLNES_ASSERT_IMP(a_init_holds_input, front_busy, in_stall)
  // A pop only happens with an entry at the queue head and a write being loaded.
  `CLNES_ASSERT_NXT(a_pop_loads_out, q_pop, out_valid)

endmodule

// File: bench/tb_char_lcd_nibble_expander_sequencer_unit.sv
// Testbench for the character LCD nibble expander sequencer: random and directed words.
`timescale 1ns / 1ps

module tb_char_lcd_nibble_expander_sequencer_unit;
  import clnes_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned PHASE_OPS   = 25;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_data;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  char_lcd_nibble_expander_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  in_word_t    lcd_ops[$];          // words waiting to be offered
  out_word_t   expected_writes[$];  // expander writes still to come
  logic [7:0]  lcd_shadow = 8'h00;
  logic [7:0]  i2c_addr = DEV_ADDR_RESET;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_given = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    mismatches++;
    $display("[%0t] %s: got %02h, want %02h", $time, what, got, want);
  endtask

  task automatic push_write();
    expected_writes.push_back(out_word_t'{i2c_addr, lcd_shadow, 1'b0});
  endtask

  task automatic pulse_enable();
    lcd_shadow[BIT_E] = 1'b1;
    push_write();
    lcd_shadow[BIT_E] = 1'b0;
    push_write();
  endtask

  task automatic send_lcd_byte(logic [7:0] b, logic rs);
    lcd_shadow[BIT_RS] = rs;
    lcd_shadow[BIT_RW] = 1'b0;
    push_write();
    lcd_shadow = {b[7:4], lcd_shadow[3:0]};
    push_write();
    pulse_enable();
    lcd_shadow = {b[3:0], lcd_shadow[3:0]};
    push_write();
    pulse_enable();
  endtask

  task automatic predict_expander_writes(in_word_t w);
    logic [7:0] dd_addr;
    dd_addr = (w.row ? CURSOR_ROW1 : CURSOR_ROW0) + {2'b00, w.column};
    case (w.action)
      ACT_CMD:    send_lcd_byte(w.value, 1'b0);
      ACT_DATA:   send_lcd_byte(w.value, 1'b1);
      ACT_CURSOR: send_lcd_byte(dd_addr, 1'b0);
      default: begin
        send_lcd_byte(CMD_FUNC_SET, 1'b0);
        send_lcd_byte(CMD_FUNC_SET, 1'b0);
        pulse_enable();
        send_lcd_byte(CMD_FUNC_SET, 1'b0);
        send_lcd_byte(CMD_DISP_ON, 1'b0);
        send_lcd_byte(CMD_CLEAR, 1'b0);
      end
    endcase
    expected_writes[expected_writes.size() - 1].last = 1'b1;
  endtask

  // Driver: offers queued words, random gap after each when gaps are on.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      send_gap   <= 0;
      lcd_shadow = 8'h00;
    end else begin
      if (in_valid && !in_stall)
        predict_expander_writes(in_data);
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (lcd_ops.size() != 0) begin
          in_data  <= lcd_ops.pop_front();
          in_valid <= 1'b1;
          send_gap <= gaps_on ? $urandom_range(0, 9) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted write, then draws the next stall.
  always @(posedge clk) begin
    out_word_t want;
    int unsigned n;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          report_mismatch("write with nothing pending", out_data.expander_byte, 8'h00);
        end else begin
          want = expected_writes.pop_front();
          if (out_data.bus_address !== want.bus_address)
            report_mismatch("bus_address", out_data.bus_address, want.bus_address);
          if (out_data.expander_byte !== want.expander_byte)
            report_mismatch("expander_byte", out_data.expander_byte, want.expander_byte);
          if (out_data.last !== want.last)
            report_mismatch("last", {7'd0, out_data.last}, {7'd0, want.last});
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (holds_asked != holds_given) begin
        holds_given <= holds_given + 1;
        hold_left   <= LONG_HOLD;
        out_stall   <= 1'b1;
      end else if (out_valid && !out_stall) begin
        n = stalls_on ? $urandom_range(0, 9) : 0;
        stall_left <= n;
        out_stall  <= (n != 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= (stall_left != 1);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic in_word_t make_word(action_t a, logic [7:0] v, logic [5:0] c, logic r);
    in_word_t w;
    w.action = a;
    w.value  = v;
    w.column = c;
    w.row    = r;
    return w;
  endfunction

  // Mostly command/data/cursor; init now and then. Ignored fields stay random.
  function automatic in_word_t rand_word();
    int unsigned r;
    action_t a;
    r = $urandom_range(0, 99);
    a = (r < 8) ? ACT_INIT : action_t'(r % 3);
    return make_word(a, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                     1'($urandom_range(0, 1)));
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (lcd_ops.size() != 0 || in_valid || expected_writes.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_address(logic [7:0] a);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= a;
    i2c_addr    = a;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] addr_plan [6];
    addr_plan = '{8'h00, 8'hFF, 8'h00, 8'h27, 8'h00, 8'hFF};
    addr_plan[2] = 8'($urandom_range(0, 255));
    addr_plan[4] = 8'($urandom_range(0, 255));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes, every action, ignored fields, cursor extremes.
    lcd_ops.push_back(make_word(ACT_CMD, 8'h00, 6'd0, 1'b0));
    lcd_ops.push_back(make_word(ACT_CMD, 8'hFF, 6'd63, 1'b1));
    lcd_ops.push_back(make_word(ACT_DATA, 8'hA5, 6'd0, 1'b0));
    lcd_ops.push_back(make_word(ACT_DATA, 8'h5A, 6'd63, 1'b1));
    lcd_ops.push_back(make_word(ACT_DATA, 8'hFF, 6'd21, 1'b0));
    lcd_ops.push_back(make_word(ACT_DATA, 8'h00, 6'd42, 1'b1));
    lcd_ops.push_back(make_word(ACT_CMD, 8'h0F, 6'd0, 1'b0));
    lcd_ops.push_back(make_word(ACT_CURSOR, 8'h00, 6'd0, 1'b0));
    lcd_ops.push_back(make_word(ACT_CURSOR, 8'hFF, 6'd63, 1'b0));
    lcd_ops.push_back(make_word(ACT_CURSOR, 8'h5A, 6'd0, 1'b1));
    lcd_ops.push_back(make_word(ACT_CURSOR, 8'hA5, 6'd63, 1'b1)); // 0xC0 + 63 = 0xFF
    lcd_ops.push_back(make_word(ACT_DATA, 8'hF0, 6'd0, 1'b0));
    lcd_ops.push_back(make_word(ACT_INIT, 8'hFF, 6'd63, 1'b1));
    lcd_ops.push_back(make_word(ACT_DATA, 8'h41, 6'd5, 1'b0));
    lcd_ops.push_back(make_word(ACT_INIT, 8'h00, 6'd0, 1'b0));
    lcd_ops.push_back(make_word(ACT_CURSOR, 8'h33, 6'd1, 1'b1));
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      write_address(addr_plan[p]);
      gaps_on   = (p != 1 && p != 4);
      stalls_on = (p != 1 && p != 3);
      // long receiver hold while words keep coming, so the input backs up
      if (p == 1)
        holds_asked++;
      repeat (PHASE_OPS) lcd_ops.push_back(rand_word());
      wait_idle();
    end

    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/clnes_pkg.sv
hdl/clnes_front.sv
hdl/clnes_queue.sv
hdl/clnes_back.sv
hdl/char_lcd_nibble_expander_sequencer_unit.sv
bench/tb_char_lcd_nibble_expander_sequencer_unit.sv
